// ===== rtl/ucl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ucl_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF  = 1024;
  localparam int CHANNEL_BITS_DEF = 16;
  localparam int CELL_COUNT_DEF   = 16;

  // Internal color count: holds up to an effective limit of 2047 plus one
  localparam int CNT_W     = 12;
  localparam int OUT_CNT_W = 11;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CMYK_EN     = 2'd2;

  localparam logic [CFG_DATA_W-1:0] COLOR_LIMIT_RST = 11'd256;

  // Control part of a token that walks down the cell chain
  typedef struct packed {
    logic valid;     // token present
    logic wr;        // store the key in the selected cell
    logic search;    // compare the key against this row
    logic last;      // final search row of the pixel
    logic hit;       // a match was found in an earlier cell
    logic cmyk_en;   // black takes part in the compare
    logic alpha_en;  // alpha takes part in the compare
  } ucl_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ucl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ucl_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ucl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ucl_cell import ucl_pkg::*; #(
  parameter int CELL_ID      = 0,
  parameter int CELL_BITS    = 4,
  parameter int ROW_BITS     = 6,
  parameter int BANK_DEPTH   = 64,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ucl_ctl_t                  ctl_in,
  input  logic [ROW_BITS-1:0]       row_in,
  input  logic [CELL_BITS-1:0]      sel_in,
  input  logic [5*CHANNEL_BITS-1:0] key_in,
  input  logic [CNT_W-1:0]          total_in,
  output ucl_ctl_t                  ctl_out,
  output logic [ROW_BITS-1:0]       row_out,
  output logic [CELL_BITS-1:0]      sel_out,
  output logic [5*CHANNEL_BITS-1:0] key_out,
  output logic [CNT_W-1:0]          total_out
);

  localparam int KEY_W = 5 * CHANNEL_BITS;
  localparam int IDX_W = ROW_BITS + CELL_BITS;
  localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam logic [CELL_BITS-1:0] MY_ID = CELL_BITS'(CELL_ID);

  logic             we;
  logic [KEY_W-1:0] rd_key;

  ucl_ctl_t               ctl_a;
  logic [ROW_BITS-1:0]    row_a;
  logic [CELL_BITS-1:0]   sel_a;
  logic [KEY_W-1:0]       key_a;
  logic [CNT_W-1:0]       total_a;

  logic     rgb_eq;
  logic     k_eq;
  logic     a_eq;
  logic     live;
  ucl_ctl_t ctl_b;

  // Write lands in this bank only when the token targets this cell
  assign we = ctl_in.valid & ctl_in.wr & (sel_in == MY_ID);

  ucl_ram #(
    .WIDTH(KEY_W),
    .DEPTH(BANK_DEPTH)
  ) u_bank (
    .clk  (clk),
    .we   (we),
    .waddr(row_in),
    .wdata(key_in),
    .raddr(row_in),
    .rdata(rd_key)
  );

  // Hold the token in a register while the bank read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else begin
      ctl_a <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    row_a   <= row_in;
    sel_a   <= sel_in;
    key_a   <= key_in;
    total_a <= total_in;
  end

  always_comb begin
    rgb_eq = (rd_key[3*CHANNEL_BITS-1:0] == key_a[3*CHANNEL_BITS-1:0]);
    k_eq   = !ctl_a.cmyk_en ||
             (rd_key[3*CHANNEL_BITS +: CHANNEL_BITS] == key_a[3*CHANNEL_BITS +: CHANNEL_BITS]);
    a_eq   = !ctl_a.alpha_en ||
             (rd_key[4*CHANNEL_BITS +: CHANNEL_BITS] == key_a[4*CHANNEL_BITS +: CHANNEL_BITS]);
    // Entry index is row * cells + cell id; only entries below the count hold colors
    live   = CMP_W'({row_a, MY_ID}) < CMP_W'(total_a);
    ctl_b     = ctl_a;
    ctl_b.hit = ctl_a.hit | (ctl_a.search & live & rgb_eq & k_eq & a_eq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_b;
    end
  end

  always_ff @(posedge clk) begin
    row_out   <= row_a;
    sel_out   <= sel_a;
    key_out   <= key_a;
    total_out <= total_a;
  end

endmodule

`default_nettype wire

// ===== rtl/unique_color_limit_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Signals                                           | Handshake
// ----------+---------------------------------------------------+------------------------
// pixel in  | red green blue black alpha first_pixel last_pixel | start & !busy
// result    | unique_count new_color exceeded verdict_valid     | done, one cycle
//           | within_limit                                      |
// config    | cfg_index cfg_data                                | cfg_we, no wait
//
// Sequence: a pixel that needs no search (first pixel of an image, empty table,
// or limit already exceeded) goes straight to the finish step. Otherwise the
// banked table is swept first: one row of the table is issued per cycle, and
// each token passes through every cell (bank read, then compare) on its way
// down the chain; the finish step follows once the last row leaves the chain.
// Reset: rst clears the count, the exceeded flag and loads the register
// defaults; the color banks are not cleared, as the count masks stale entries.
// Stalls: the result receiver cannot stall; done pulses for one cycle and the
// next pixel may transfer in that same cycle.

module unique_color_limit_check import ucl_pkg::*; #(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int CELL_COUNT   = CELL_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // pixel command
  input  logic                    start,
  output logic                    busy,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  input  logic [CHANNEL_BITS-1:0] black,
  input  logic [CHANNEL_BITS-1:0] alpha,
  input  logic                    first_pixel,
  input  logic                    last_pixel,
  // result
  output logic                    done,
  output logic [OUT_CNT_W-1:0]    unique_count,
  output logic                    new_color,
  output logic                    exceeded,
  output logic                    verdict_valid,
  output logic                    within_limit,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  // Table geometry: entry k lives in cell (k mod CELL_COUNT), row (k / CELL_COUNT)
  localparam int CELL_BITS  = $clog2(CELL_COUNT);
  localparam int BANK_DEPTH = TABLE_DEPTH / CELL_COUNT;
  localparam int ROW_BITS   = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int IDX_W      = ROW_BITS + CELL_BITS;
  localparam int CMP_W      = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int KEY_W      = 5 * CHANNEL_BITS;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers
  logic [CFG_DATA_W-1:0] color_limit;
  logic                  alpha_enable;
  logic                  cmyk_enable;

  // Image state
  logic [CNT_W-1:0] total;
  logic             over;
  logic             found;

  // Pixel under work
  logic [KEY_W-1:0]    key;
  logic                last_flag;
  logic [ROW_BITS-1:0] row_cnt;

  // Chain wiring: index 0 is the injection point, CELL_COUNT the exit
  ucl_ctl_t                chain_ctl   [CELL_COUNT+1];
  logic [ROW_BITS-1:0]     chain_row   [CELL_COUNT+1];
  logic [CELL_BITS-1:0]    chain_sel   [CELL_COUNT+1];
  logic [KEY_W-1:0]        chain_key   [CELL_COUNT+1];
  logic [CNT_W-1:0]        chain_total [CELL_COUNT+1];

  logic                accept;
  logic [CNT_W-1:0]    limit;
  logic [CMP_W-1:0]    total_x;
  logic [CMP_W-1:0]    total_m1;
  logic [ROW_BITS-1:0] rows_last;
  logic                sweep_last;
  logic                exit_last;
  logic                insert;
  logic                store;
  logic [CNT_W-1:0]    total_inc;
  logic                over_next;
  logic [CNT_W-1:0]    total_eff;
  logic                over_eff;

  assign busy   = (state != S_IDLE);
  assign accept = start & !busy;

  // first_pixel restarts the image before this pixel is looked up
  assign total_eff = first_pixel ? '0 : total;
  assign over_eff  = first_pixel ? 1'b0 : over;

  // Effective limit is color_limit capped at the table size
  always_comb begin
    if (32'(color_limit) < TABLE_DEPTH) begin
      limit = CNT_W'(color_limit);
    end else begin
      limit = CNT_W'(TABLE_DEPTH);
    end
  end

  // Last row to sweep: (count - 1) / CELL_COUNT; count is nonzero while sweeping
  assign total_x    = CMP_W'(total);
  assign total_m1   = total_x - CMP_W'(1);
  assign rows_last  = total_m1[CELL_BITS +: ROW_BITS];
  assign sweep_last = (row_cnt == rows_last);

  assign exit_last = chain_ctl[CELL_COUNT].valid & chain_ctl[CELL_COUNT].search &
                     chain_ctl[CELL_COUNT].last;

  // Outcome of the pixel; the color that passes the limit is counted, not stored
  assign insert    = !over && !found;
  assign total_inc = total + CNT_W'(1);
  assign store     = insert && (total < limit);
  assign over_next = over | (insert && (total_inc > limit));

  // Token injection: search rows while sweeping, the store on finish
  always_comb begin
    chain_ctl[0]   = '0;
    chain_row[0]   = row_cnt;
    chain_sel[0]   = '0;
    chain_key[0]   = key;
    chain_total[0] = total;
    unique case (state)
      S_SWEEP: begin
        chain_ctl[0].valid    = 1'b1;
        chain_ctl[0].search   = 1'b1;
        chain_ctl[0].last     = sweep_last;
        chain_ctl[0].cmyk_en  = cmyk_enable;
        chain_ctl[0].alpha_en = alpha_enable;
      end
      S_FINISH: begin
        chain_ctl[0].valid = store;
        chain_ctl[0].wr    = store;
        chain_row[0]       = total_x[CELL_BITS +: ROW_BITS];
        chain_sel[0]       = total_x[CELL_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CELL_COUNT; gi++) begin : g_cell
      ucl_cell #(
        .CELL_ID     (gi),
        .CELL_BITS   (CELL_BITS),
        .ROW_BITS    (ROW_BITS),
        .BANK_DEPTH  (BANK_DEPTH),
        .CHANNEL_BITS(CHANNEL_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl_in   (chain_ctl[gi]),
        .row_in   (chain_row[gi]),
        .sel_in   (chain_sel[gi]),
        .key_in   (chain_key[gi]),
        .total_in (chain_total[gi]),
        .ctl_out  (chain_ctl[gi+1]),
        .row_out  (chain_row[gi+1]),
        .sel_out  (chain_sel[gi+1]),
        .key_out  (chain_key[gi+1]),
        .total_out(chain_total[gi+1])
      );
    end
  endgenerate

  // Control: configuration, sequencer, image state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      color_limit  <= COLOR_LIMIT_RST;
      alpha_enable <= 1'b0;
      cmyk_enable  <= 1'b0;
      total        <= '0;
      over         <= 1'b0;
      found        <= 1'b0;
      row_cnt      <= '0;
      done         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLOR_LIMIT: color_limit  <= cfg_data;
          CFG_ALPHA_EN:    alpha_enable <= cfg_data[0];
          CFG_CMYK_EN:     cmyk_enable  <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // Pulse the result strobe in the cycle after the finish step
      done <= (state == S_FINISH);

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            total   <= total_eff;
            over    <= over_eff;
            found   <= 1'b0;
            row_cnt <= '0;
            // Skip the sweep when nothing is stored or the image is already over
            if (over_eff || (total_eff == '0)) begin
              state <= S_FINISH;
            end else begin
              state <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          row_cnt <= row_cnt + ROW_BITS'(1);
          if (sweep_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (exit_last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (insert) begin
            total <= total_inc;
          end
          over  <= over_next;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Collect hits as search tokens leave the chain
      if (chain_ctl[CELL_COUNT].valid && chain_ctl[CELL_COUNT].search &&
          chain_ctl[CELL_COUNT].hit) begin
        found <= 1'b1;
      end
    end
  end

  // Payload: latch the pixel on transfer, the result on finish
  always_ff @(posedge clk) begin
    if (accept) begin
      key       <= {alpha, black, blue, green, red};
      last_flag <= last_pixel;
    end
    if (state == S_FINISH) begin
      unique_count  <= insert ? total_inc[OUT_CNT_W-1:0] : total[OUT_CNT_W-1:0];
      new_color     <= insert;
      exceeded      <= over_next;
      verdict_valid <= last_flag;
      within_limit  <= last_flag & !over_next;
    end
  end

  // A result follows only a finish step
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FINISH))
    else $error("done without a preceding finish step");

  // No search token may leave the chain once the block is free
  a_chain_clear_when_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !(chain_ctl[CELL_COUNT].valid && chain_ctl[CELL_COUNT].search))
    else $error("search token left the chain while idle");

  // A transferred pixel keeps the block busy in the next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after a pixel transfer");

  // The result pulse lands when the block is free again
  a_idle_on_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result pulse while still busy");

endmodule

`default_nettype wire

// ===== bench/tb_unique_color_limit_check.sv =====
`timescale 1ns / 1ps

module tb_unique_color_limit_check;
  import ucl_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int CB    = CHANNEL_BITS_DEF;

  typedef struct packed {
    logic [CB-1:0] red, green, blue, black, alpha;
    logic          first_pixel, last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] unique_count;
    logic                 new_color, exceeded, verdict_valid, within_limit;
  } tally_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [CB-1:0]         red = '0, green = '0, blue = '0, black = '0, alpha = '0;
  logic                  first_pixel = 1'b0, last_pixel = 1'b0;
  logic                  done;
  logic [OUT_CNT_W-1:0]  unique_count;
  logic                  new_color, exceeded, verdict_valid, within_limit;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_COLOR_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  unique_color_limit_check uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red(red), .green(green), .blue(blue), .black(black), .alpha(alpha),
    .first_pixel(first_pixel), .last_pixel(last_pixel),
    .done(done), .unique_count(unique_count), .new_color(new_color),
    .exceeded(exceeded), .verdict_valid(verdict_valid), .within_limit(within_limit),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the color table, the count and the exceeded flag
  logic [3*CB-1:0]       rgb_seen [DEPTH];
  logic [2*CB-1:0]       ka_seen  [DEPTH];
  int                    seen_total = 0;
  bit                    seen_over = 1'b0;

  // Shadow of the configuration registers
  logic [CFG_DATA_W-1:0] lim_shadow = COLOR_LIMIT_RST;
  bit                    alpha_shadow = 1'b0;
  bit                    black_shadow = 1'b0;

  pixel_t                pix_q [$];    // pixels waiting to be offered
  tally_t                tally_q [$];  // expected results, oldest first
  pixel_t                offered;      // pixel currently on the input ports
  tally_t                want;
  bit                    steady = 1'b0;  // suppress sender idling
  int                    mismatch_count = 0;

  // Advance the shadow state by one pixel and return the result it should give.
  function automatic tally_t count_pixel(pixel_t p);
    tally_t t;
    int     eff;
    int     k;
    bit     found;
    bit     added;
    eff = (lim_shadow < DEPTH) ? int'(lim_shadow) : DEPTH;
    found = 1'b0;
    added = 1'b0;
    if (p.first_pixel) begin
      seen_total = 0;
      seen_over = 1'b0;
    end
    if (!seen_over) begin
      for (k = 0; k < seen_total && !found; k++) begin
        if (rgb_seen[k] == {p.red, p.green, p.blue} &&
            (!black_shadow || ka_seen[k][2*CB-1:CB] == p.black) &&
            (!alpha_shadow || ka_seen[k][CB-1:0] == p.alpha))
          found = 1'b1;
      end
      if (!found) begin
        // the color that passes the limit is counted but not stored
        if (seen_total < eff) begin
          rgb_seen[seen_total] = {p.red, p.green, p.blue};
          ka_seen[seen_total]  = {p.black, p.alpha};
        end
        seen_total++;
        added = 1'b1;
        if (seen_total > eff) seen_over = 1'b1;
      end
    end
    t.unique_count  = seen_total[OUT_CNT_W-1:0];
    t.new_color     = added;
    t.exceeded      = seen_over;
    t.verdict_valid = p.last_pixel;
    t.within_limit  = p.last_pixel && !seen_over;
    return t;
  endfunction

  // Driver: hold the offered pixel until it transfers, then offer the next one
  // or idle. start is assigned once per edge.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) tally_q.push_back(count_pixel(offered));
      if (!(start && busy)) begin
        if (pix_q.size() != 0 && (steady || $urandom_range(99) >= 21)) begin
          offered = pix_q.pop_front();
          start       <= 1'b1;
          red         <= offered.red;
          green       <= offered.green;
          blue        <= offered.blue;
          black       <= offered.black;
          alpha       <= offered.alpha;
          first_pixel <= offered.first_pixel;
          last_pixel  <= offered.last_pixel;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // Monitor: every done pulse is a result transfer; compare it with the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (tally_q.size() == 0) begin
        $error("unique_count: expected no result, got %0d", unique_count);
        mismatch_count++;
      end else begin
        want = tally_q.pop_front();
        check_field("unique_count", 32'(want.unique_count), 32'(unique_count));
        check_field("new_color", 32'(want.new_color), 32'(new_color));
        check_field("exceeded", 32'(want.exceeded), 32'(exceeded));
        check_field("verdict_valid", 32'(want.verdict_valid), 32'(verdict_valid));
        check_field("within_limit", 32'(want.within_limit), 32'(within_limit));
      end
    end
  end

  // Wait until every pixel has transferred and every result has come back.
  task automatic drain();
    do @(negedge clk); while (pix_q.size() != 0 || start || tally_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COLOR_LIMIT: lim_shadow = val;
      CFG_ALPHA_EN:    alpha_shadow = val[0];
      CFG_CMYK_EN:     black_shadow = val[0];
      default: ;
    endcase
  endtask

  function automatic pixel_t pixel_of(logic [CB-1:0] r, g, b, k, a, logic f, l);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.black = k;
    p.alpha = a;
    p.first_pixel = f;
    p.last_pixel = l;
    return p;
  endfunction

  // Favor the channel extremes now and then.
  function automatic logic [CB-1:0] rand_chan();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return CB'($urandom);
    endcase
  endfunction

  // Queue one image drawn from a small palette so that colors repeat. Some
  // palette entries share red, green and blue with an earlier one and differ
  // only in black or alpha. Most images are well formed; a few lack the
  // first or last mark or carry stray marks.
  task automatic gen_image(inout int n);
    pixel_t pal [$];
    pixel_t p;
    int     npal, len, cap, i;
    cap = (lim_shadow < 40) ? int'(lim_shadow) : 40;
    npal = $urandom_range(1, cap + 3);
    for (i = 0; i < npal; i++) begin
      if (i > 0 && $urandom_range(2) == 0) begin
        p = pal[$urandom_range(i - 1)];
        if ($urandom_range(1)) p.black = rand_chan();
        else p.alpha = rand_chan();
      end else begin
        p = pixel_of(rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                     1'b0, 1'b0);
      end
      pal.push_back(p);
    end
    len = $urandom_range(1, 2 * npal + 4);
    for (i = 0; i < len; i++) begin
      p = pal[$urandom_range(npal - 1)];
      p.first_pixel = (i == 0) && ($urandom_range(9) != 0);
      p.last_pixel  = (i == len - 1) && ($urandom_range(9) != 0);
      if ($urandom_range(24) == 0) begin
        p.first_pixel = 1'($urandom_range(1));
        p.last_pixel  = 1'($urandom_range(1));
        if ($urandom_range(1)) p.red = rand_chan();
      end
      pix_q.push_back(p);
      n++;
    end
  endtask

  initial begin
    int     rand_items;
    int     phase;
    int     i;
    pixel_t p;
    logic [CFG_DATA_W-1:0] lim;

    rand_items = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings. No first mark right after reset: carry on from the
    // reset state. Black and alpha do not count while disabled.
    pix_q.push_back(pixel_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0));
    pix_q.push_back(pixel_of(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 0, 0));
    pix_q.push_back(pixel_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 0, 1));
    // one-pixel image
    pix_q.push_back(pixel_of(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1, 1));

    // Limit of two with both extra channels compared: the third color passes
    // the limit, later pixels are ignored, the verdict fails.
    write_reg(CFG_COLOR_LIMIT, 11'd2);
    write_reg(CFG_ALPHA_EN, 11'd1);
    write_reg(CFG_CMYK_EN, 11'd1);
    pix_q.push_back(pixel_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0));
    pix_q.push_back(pixel_of(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 0, 0));
    pix_q.push_back(pixel_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 0, 0));
    pix_q.push_back(pixel_of(16'h1234, 16'h5678, 16'h9ABC, 16'h0000, 16'h0000, 0, 0));
    pix_q.push_back(pixel_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 1));

    // Toggle alpha in the middle of an image: the new setting applies to
    // the colors already stored.
    write_reg(CFG_COLOR_LIMIT, 11'd4);
    write_reg(CFG_ALPHA_EN, 11'd0);
    pix_q.push_back(pixel_of(16'h0005, 16'h0005, 16'h0005, 16'h0007, 16'h0009, 1, 0));
    pix_q.push_back(pixel_of(16'h0005, 16'h0005, 16'h0005, 16'h0007, 16'h000A, 0, 0));
    write_reg(CFG_ALPHA_EN, 11'd1);
    pix_q.push_back(pixel_of(16'h0005, 16'h0005, 16'h0005, 16'h0007, 16'h000A, 0, 0));
    pix_q.push_back(pixel_of(16'h0005, 16'h0005, 16'h0005, 16'h0008, 16'h0009, 0, 1));

    // Limit of zero: the first pixel already exceeds.
    write_reg(CFG_COLOR_LIMIT, 11'd0);
    pix_q.push_back(pixel_of(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1, 1));
    pix_q.push_back(pixel_of(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 0, 1));

    // Limit of one: a single color stays within, a second one does not.
    write_reg(CFG_COLOR_LIMIT, 11'd1);
    pix_q.push_back(pixel_of(16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h3C3C, 1, 0));
    pix_q.push_back(pixel_of(16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h3C3C, 0, 1));
    pix_q.push_back(pixel_of(16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h3C3C, 1, 0));
    pix_q.push_back(pixel_of(16'h00FE, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h3C3C, 0, 1));

    // Fill the whole table under the largest register value, which the block
    // caps at the table depth: the color after the last free entry exceeds.
    write_reg(CFG_COLOR_LIMIT, 11'h7FF);
    write_reg(CFG_ALPHA_EN, 11'($urandom_range(1)));
    write_reg(CFG_CMYK_EN, 11'($urandom_range(1)));
    for (i = 0; i < DEPTH + 2; i++) begin
      p = pixel_of(CB'(i), rand_chan(), rand_chan(), rand_chan(), rand_chan(), i == 0, 0);
      pix_q.push_back(p);
    end
    for (i = 0; i < 3; i++) begin
      p = pixel_of(CB'(5), rand_chan(), rand_chan(), rand_chan(), rand_chan(), 0, i == 2);
      pix_q.push_back(p);
    end

    // Random phases, each under its own settings.
    while (rand_items < 700) begin
      phase++;
      case ($urandom_range(9))
        0:       lim = 11'd0;
        1:       lim = 11'd1;
        2:       lim = 11'd2;
        3:       lim = 11'd1024;
        4:       lim = 11'h7FF;
        5:       lim = COLOR_LIMIT_RST;
        default: lim = 11'($urandom_range(1, 40));
      endcase
      write_reg(CFG_COLOR_LIMIT, lim);
      write_reg(CFG_ALPHA_EN, 11'($urandom_range(1)));
      write_reg(CFG_CMYK_EN, 11'($urandom_range(1)));
      steady = (phase == 3);
      repeat ($urandom_range(2, 5)) gen_image(rand_items);
    end

    drain();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** unique_color_limit_check: PASSED **");
    end else begin
      $display("** unique_color_limit_check: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** unique_color_limit_check: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ucl_pkg.sv
rtl/ucl_ram.sv
rtl/ucl_cell.sv
rtl/unique_color_limit_check.sv
bench/tb_unique_color_limit_check.sv
